[hw/rtl/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, types and helper functions for the infix-to-postfix unit.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] CH_POW   = 8'h5E;
  localparam logic [SYM_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;

  // whole-stack operations
  localparam logic [1:0] STK_HOLD = 2'd0;
  localparam logic [1:0] STK_PUSH = 2'd1;
  localparam logic [1:0] STK_POP  = 2'd2;
  localparam logic [1:0] STK_REPL = 2'd3;

  // per-cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_UP   = 2'd1;  // load from cell above (push side)
  localparam logic [1:0] CELL_DOWN = 2'd2;  // load from cell below (pop side)

  typedef struct packed {
    logic [1:0]       op;
    logic [SYM_W-1:0] din;
  } stk_ctrl_t;

  typedef struct packed {
    logic [SYM_W-1:0] top;
    logic [SYM_W-1:0] next;
  } stk_stat_t;

  // unknown characters rank lowest (0) so they pop everything
  function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_POW) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_operand(input logic [SYM_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

[hw/rtl/itp_cell.sv]
// ----------------------------------------------------------------------------
// itp_cell
// One stack entry; shifts toward the top or the bottom with its neighbors.
// ----------------------------------------------------------------------------
module itp_cell (
  input  logic                      clk,
  input  logic [1:0]                op,
  input  logic [itp_pkg::SYM_W-1:0] from_up,
  input  logic [itp_pkg::SYM_W-1:0] from_down,
  output logic [itp_pkg::SYM_W-1:0] q
);

  logic [itp_pkg::SYM_W-1:0] data_r;
  logic [itp_pkg::SYM_W-1:0] data_nxt;

  always_comb begin
    unique case (op)
      itp_pkg::CELL_UP:   data_nxt = from_up;
      itp_pkg::CELL_DOWN: data_nxt = from_down;
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

[hw/rtl/itp_stack.sv]
// ----------------------------------------------------------------------------
// itp_stack
// Operator stack built as a chain of shifting cells; cell 0 is the top.
// ----------------------------------------------------------------------------
module itp_stack (
  input  logic               clk,
  input  itp_pkg::stk_ctrl_t ctrl,
  output itp_pkg::stk_stat_t stat
);

  logic [itp_pkg::SYM_W-1:0] q     [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::SYM_W-1:0] up_d  [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::SYM_W-1:0] dn_d  [itp_pkg::STACK_DEPTH];
  logic [1:0]                c_op  [itp_pkg::STACK_DEPTH];

  genvar i;
  generate
    for (i = 0; i < itp_pkg::STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
        assign up_d[i] = ctrl.din;
      end else begin : g_mid
        assign up_d[i] = q[i-1];
      end
      if (i == itp_pkg::STACK_DEPTH - 1) begin : g_bot
        assign dn_d[i] = '0;
      end else begin : g_nb
        assign dn_d[i] = q[i+1];
      end

      always_comb begin
        unique case (ctrl.op)
          itp_pkg::STK_PUSH: c_op[i] = itp_pkg::CELL_UP;
          itp_pkg::STK_POP:  c_op[i] = itp_pkg::CELL_DOWN;
          itp_pkg::STK_REPL: c_op[i] = (i == 0) ? itp_pkg::CELL_UP : itp_pkg::CELL_HOLD;
          default:           c_op[i] = itp_pkg::CELL_HOLD;
        endcase
      end

      itp_cell u_cell (
        .clk       (clk),
        .op        (c_op[i]),
        .from_up   (up_d[i]),
        .from_down (dn_d[i]),
        .q         (q[i])
      );
    end
  endgenerate

  assign stat.top  = q[0];
  assign stat.next = q[1];

endmodule

[hw/rtl/infix_to_postfix_converter_unit.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard infix to postfix converter over a shifting operator stack.
// ----------------------------------------------------------------------------
// Sequence: an accepted word is registered, then handled in the work state;
//   each result is registered at the output, and each stack pop is a step.
// Input: a new word is taken only after the work state has popped every
//   entry due or discarded its '(' and, for an end word, sent the terminator.
//   The whole stack shifts one place per cycle unless the output stalls.
// Reset: rst_n synchronous, active low; empties the stack and the output.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] symbol
  input  logic       in_tuser,   // [0] end_of_expr
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_symbol
  output logic       out_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic                                state_r, state_nxt;
  logic [itp_pkg::SYM_W-1:0]           sym_r;
  logic                                eoe_r;
  logic [itp_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                                out_valid_r;
  logic [itp_pkg::SYM_W-1:0]           out_data_r;
  logic                                out_last_r;

  itp_pkg::stk_ctrl_t                  stk_ctrl;
  itp_pkg::stk_stat_t                  stk_stat;

  logic                                out_ok;
  logic                                step;
  logic                                emit;
  logic [itp_pkg::SYM_W-1:0]           emit_data;
  logic                                emit_last;
  logic                                done;
  logic [1:0]                          op_sel;
  logic [itp_pkg::CNT_W-1:0]           cnt_sel;
  logic [1:0]                          p_in;
  logic                                full;

  assign out_ok    = !out_valid_r || out_tready;
  assign step      = (state_r == ST_WORK) && out_ok;
  assign in_tready = (state_r == ST_IDLE);
  assign p_in      = itp_pkg::prec_of(sym_r);
  assign full      = (cnt_r == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));

  always_comb begin
    op_sel    = itp_pkg::STK_HOLD;
    cnt_sel   = cnt_r;
    emit      = 1'b0;
    emit_data = stk_stat.top;
    emit_last = 1'b0;
    done      = 1'b0;
    priority if (eoe_r) begin
      if (cnt_r != '0) begin
        emit    = 1'b1;
        op_sel  = itp_pkg::STK_POP;
        cnt_sel = cnt_r - 1'b1;
      end else begin
        emit      = 1'b1;
        emit_data = itp_pkg::CH_NUL;
        emit_last = 1'b1;
        done      = 1'b1;
      end
    end else if (itp_pkg::is_operand(sym_r)) begin
      emit      = 1'b1;
      emit_data = sym_r;
      emit_last = 1'b1;
      done      = 1'b1;
    end else if (sym_r == itp_pkg::CH_LPAR) begin
      if (!full) begin
        op_sel  = itp_pkg::STK_PUSH;
        cnt_sel = cnt_r + 1'b1;
      end
      done = 1'b1;
    end else if (sym_r == itp_pkg::CH_RPAR) begin
      if (cnt_r != '0 && stk_stat.top != itp_pkg::CH_LPAR) begin
        emit      = 1'b1;
        op_sel    = itp_pkg::STK_POP;
        cnt_sel   = cnt_r - 1'b1;
        emit_last = (cnt_r == itp_pkg::CNT_W'(1)) || (stk_stat.next == itp_pkg::CH_LPAR);
        done      = (cnt_r == itp_pkg::CNT_W'(1));
      end else begin
        if (cnt_r != '0) begin
          op_sel  = itp_pkg::STK_POP;
          cnt_sel = cnt_r - 1'b1;
        end
        done = 1'b1;
      end
    end else begin
      if (cnt_r != '0 && p_in <= itp_pkg::prec_of(stk_stat.top)) begin
        emit = 1'b1;
        if (cnt_r > itp_pkg::CNT_W'(1) && p_in <= itp_pkg::prec_of(stk_stat.next)) begin
          op_sel  = itp_pkg::STK_POP;
          cnt_sel = cnt_r - 1'b1;
        end else begin
          // last pop: the new operator takes the freed top slot
          op_sel    = itp_pkg::STK_REPL;
          emit_last = 1'b1;
          done      = 1'b1;
        end
      end else begin
        if (!full) begin
          op_sel  = itp_pkg::STK_PUSH;
          cnt_sel = cnt_r + 1'b1;
        end
        done = 1'b1;
      end
    end
  end

  assign stk_ctrl.op  = step ? op_sel : itp_pkg::STK_HOLD;
  assign stk_ctrl.din = sym_r;
  assign cnt_nxt      = step ? cnt_sel : cnt_r;

  always_comb begin
    state_nxt = state_r;
    if (state_r == ST_IDLE) begin
      if (in_tvalid) state_nxt = ST_WORK;
    end else if (step && done) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_ok) out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sym_r <= in_tdata;
      eoe_r <= in_tuser;
    end
    if (step && emit) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
    end
  end

  itp_stack u_stack (
    .clk  (clk),
    .ctrl (stk_ctrl),
    .stat (stk_stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/itp_checker.sv]
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the infix-to-postfix unit, bound to the top level.
// ----------------------------------------------------------------------------
module itp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous word still in work");

  // reset leaves the unit empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("unit not empty after reset");

  // an operand word gives its own character as a single last word
  a_operand_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser && !out_tvalid &&
    ((in_tdata >= 8'h61 && in_tdata <= 8'h7A) || (in_tdata >= 8'h30 && in_tdata <= 8'h39))
    |=> ##1 out_tvalid && out_tlast && out_tdata == $past(in_tdata, 2))
    else $error("operand not passed through");

endmodule

bind infix_to_postfix_converter_unit itp_checker u_itp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
